### rtl/infix_expression_evaluator_assert.svh
// Assertion macros used by the evaluator datapath.
// Needs nothing else; included by files that check their own logic.
`ifndef INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IEE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define IEE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/iee_pkg.sv
// Types and constants for the infix expression evaluator.
// No dependencies; imported by every module of the block.
package iee_pkg;

  localparam int OPERAND_DEPTH_DEF = 3;
  localparam int OPERATOR_DEPTH = 2;
  localparam logic [4:0] RADIX_RESET = 5'd10;
  localparam logic [9:0] FRACTION_SCALE = 10'd1000;

  localparam logic [4:0] SYM_PLUS   = 5'd16;
  localparam logic [4:0] SYM_MINUS  = 5'd17;
  localparam logic [4:0] SYM_DIVIDE = 5'd19;

  typedef enum logic [1:0] {
    OP_PLUS  = 2'd0,
    OP_MINUS = 2'd1,
    OP_TIMES = 2'd2,
    OP_DIV   = 2'd3
  } iee_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DIV_ZERO  = 2'd1,
    ST_MALFORMED = 2'd2
  } iee_status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_PUSHNUM, S_CHECK, S_POPOP, S_POPB, S_POPA,
    S_EXEC, S_DIVWAIT, S_PUSHRES, S_PUSHOP, S_READ0, S_EMIT
  } iee_state_t;

  typedef enum logic [2:0] {
    D_IDLE, D_QUO, D_MUL, D_FRAC, D_DONE
  } iee_div_state_t;

  typedef struct packed {
    logic load_in;
    logic mac;
    logic set_neg;
    logic mark_bad;
    logic push_num;
    logic pop_op;
    logic pop_b;
    logic pop_a;
    logic exec;
    logic push_res;
    logic push_op;
    logic read0;
    logic emit;
  } iee_cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic is_minus;
    logic last;
    logic after_op;
    logic op_low;
    logic opr_nz;
    logic opr_top_hi;
    logic div_needed;
    logic div_done;
    logic out_free;
  } iee_stat_t;

endpackage

### rtl/iee_div.sv
// Iterative signed 16-bit divider with thousandths of the remainder.
// Depends on iee_pkg. One quotient bit per cycle, then ten fraction bits when the remainder is nonzero.
module iee_div
  import iee_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] a,
  input  logic [15:0] b,
  output logic        done,
  output logic [15:0] quo,
  output logic        rem_nz,
  output logic [9:0]  frac
);

  iee_div_state_t state, state_next;
  logic        neg_q;
  logic [15:0] num;
  logic [15:0] den;
  logic [15:0] rem;
  logic [25:0] fr;
  logic [25:0] dsh;
  logic [9:0]  fq;
  logic [3:0]  cnt;
  logic [16:0] rem_sh;
  logic        q_bit;

  assign rem_sh = {rem, num[15]};
  assign q_bit  = rem_sh >= {1'b0, den};

  always_comb begin
    state_next = state;
    case (state)
      D_IDLE: if (start) state_next = D_QUO;
      D_QUO:  if (cnt == 4'd0) state_next = D_MUL;
      D_MUL:  state_next = (rem == 16'd0) ? D_DONE : D_FRAC;
      D_FRAC: if (cnt == 4'd0) state_next = D_DONE;
      D_DONE: state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        if (start) begin
          neg_q <= a[15] ^ b[15];
          num   <= a[15] ? 16'(-a) : a;
          den   <= b[15] ? 16'(-b) : b;
          rem   <= '0;
          cnt   <= 4'd15;
        end
      end
      D_QUO: begin
        rem <= q_bit ? 16'(rem_sh - {1'b0, den}) : rem_sh[15:0];
        num <= {num[14:0], q_bit};
        cnt <= cnt - 4'd1;
      end
      D_MUL: begin
        fr  <= {10'd0, rem} * {16'd0, FRACTION_SCALE};
        dsh <= {1'b0, den, 9'd0};
        fq  <= '0;
        cnt <= 4'd9;
      end
      D_FRAC: begin
        if (fr >= dsh) begin
          fr <= fr - dsh;
        end
        fq  <= {fq[8:0], fr >= dsh};
        dsh <= dsh >> 1;
        cnt <= cnt - 4'd1;
      end
      default: ;
    endcase
  end

  assign done   = state == D_DONE;
  assign quo    = neg_q ? 16'(-num) : num;
  assign rem_nz = rem != 16'd0;
  assign frac   = fq;

endmodule

### rtl/iee_ctrl.sv
// Sequencing state machine for the evaluator.
// Depends on iee_pkg; drives the datapath by command and status structs.
module iee_ctrl
  import iee_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  iee_stat_t stat,
  output iee_cmd_t  cmd
);

  iee_state_t state, state_next;
  logic       fin, fin_next;
  logic       reduce;

  // reduce while operators remain; operator pass stops at lower precedence
  assign reduce = stat.opr_nz && (fin || stat.op_low || stat.opr_top_hi);

  always_comb begin
    state_next = state;
    fin_next   = fin;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        fin_next = 1'b0;
        if (stat.is_digit) begin
          fin_next   = stat.last;
          state_next = stat.last ? S_PUSHNUM : S_IDLE;
        end else if (stat.is_op) begin
          if (stat.last) begin
            state_next = S_EMIT;
          end else if (stat.is_minus && stat.after_op) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_PUSHNUM;
          end
        end else begin
          state_next = stat.last ? S_EMIT : S_IDLE;
        end
      end
      S_PUSHNUM: state_next = S_CHECK;
      S_CHECK: begin
        if (reduce) begin
          state_next = S_POPOP;
        end else begin
          state_next = fin ? S_READ0 : S_PUSHOP;
        end
      end
      S_POPOP:   state_next = S_POPB;
      S_POPB:    state_next = S_POPA;
      S_POPA:    state_next = S_EXEC;
      S_EXEC:    state_next = stat.div_needed ? S_DIVWAIT : S_PUSHRES;
      S_DIVWAIT: if (stat.div_done) state_next = S_PUSHRES;
      S_PUSHRES: state_next = S_CHECK;
      S_PUSHOP:  state_next = S_IDLE;
      S_READ0:   state_next = S_EMIT;
      S_EMIT:    if (stat.out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: cmd.load_in = in_valid;
      S_DECODE: begin
        cmd.mac      = stat.is_digit;
        cmd.set_neg  = stat.is_op && !stat.last && stat.is_minus && stat.after_op;
        cmd.mark_bad = !stat.is_digit && !stat.is_op;
      end
      S_PUSHNUM: cmd.push_num = 1'b1;
      S_POPOP:   cmd.pop_op = 1'b1;
      S_POPB:    cmd.pop_b = 1'b1;
      S_POPA:    cmd.pop_a = 1'b1;
      S_EXEC:    cmd.exec = 1'b1;
      S_PUSHRES: cmd.push_res = 1'b1;
      S_PUSHOP:  cmd.push_op = 1'b1;
      S_READ0:   cmd.read0 = 1'b1;
      S_EMIT:    cmd.emit = stat.out_free;
      default: ;
    endcase
  end

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      fin   <= fin_next;
    end
  end

endmodule

### rtl/iee_dp.sv
// Datapath: radix register, accumulator, operand and operator stacks,
// arithmetic unit and result register. Depends on iee_pkg, iee_div and the assert header.
`include "infix_expression_evaluator_assert.svh"
module iee_dp
  import iee_pkg::*;
#(
  parameter int OPERAND_DEPTH = OPERAND_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic [4:0]  symbol,
  input  logic        last,
  input  iee_cmd_t    cmd,
  output iee_stat_t   stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] value,
  output logic [1:0]  status,
  output logic        has_fraction,
  output logic [9:0]  fraction_thousandths
);

  localparam int CW = $clog2(OPERAND_DEPTH + 1);
  localparam int IW = $clog2(OPERAND_DEPTH);

  logic [4:0]  radix;
  logic [4:0]  sym;
  logic        sym_last;
  logic [15:0] acc;
  logic        neg;
  logic        after_op;
  logic        frac_flag;
  logic [9:0]  frac_val;
  logic [1:0]  err;
  logic [15:0] opnd [OPERAND_DEPTH];
  logic [CW-1:0] opnd_count;
  logic [1:0]  opr [OPERATOR_DEPTH];
  logic [1:0]  opr_count;
  logic [1:0]  cur_op;
  logic [15:0] opa;
  logic [15:0] opb;
  logic [15:0] res;
  logic [15:0] value_r;

  logic [CW-1:0] opnd_dec;
  logic [IW-1:0] rd_idx;
  logic [15:0]   rd_val;
  logic [15:0]   pop_val;
  logic [15:0]   push_val;
  logic          push;
  logic          opr_idx;
  logic          div_start;
  logic          div_done;
  logic [15:0]   div_quo;
  logic          div_rem_nz;
  logic [9:0]    div_frac;
  logic [1:0]    final_st;

  assign opnd_dec = opnd_count - CW'(1);
  assign rd_idx   = cmd.read0 ? '0 : opnd_dec[IW-1:0];
  assign rd_val   = opnd[rd_idx];
  assign pop_val  = (opnd_count == '0) ? 16'd0 : rd_val;
  assign push     = cmd.push_num || cmd.push_res;
  assign push_val = cmd.push_num ? (neg ? 16'(-acc) : acc) : res;
  assign opr_idx  = opr_count == 2'd2;

  assign stat.is_digit   = !sym[4];
  assign stat.is_op      = sym >= SYM_PLUS && sym <= SYM_DIVIDE;
  assign stat.is_minus   = sym == SYM_MINUS;
  assign stat.last       = sym_last;
  assign stat.after_op   = after_op;
  assign stat.op_low     = !sym[1];
  assign stat.opr_nz     = opr_count != 2'd0;
  assign stat.opr_top_hi = opr[opr_idx][1];
  assign stat.div_needed = cur_op == OP_DIV && opb != 16'd0;
  assign stat.div_done   = div_done;
  assign stat.out_free   = !out_valid || out_ready;

  assign div_start = cmd.exec && stat.div_needed;

  iee_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .a      (opa),
    .b      (opb),
    .done   (div_done),
    .quo    (div_quo),
    .rem_nz (div_rem_nz),
    .frac   (div_frac)
  );

  always_comb begin
    final_st = err;
    if (err == ST_OK && stat.is_op) begin
      final_st = ST_MALFORMED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sym      <= symbol;
      sym_last <= last;
    end
    if (cmd.pop_op) cur_op <= opr[opr_idx];
    if (cmd.pop_b) opb <= pop_val;
    if (cmd.pop_a) opa <= pop_val;
    if (cmd.exec) begin
      case (cur_op)
        OP_PLUS:  res <= opa + opb;
        OP_MINUS: res <= opa - opb;
        OP_TIMES: res <= 16'(opa * opb);
        default:  res <= 16'd0;
      endcase
    end else if (div_done) begin
      res <= div_quo;
    end
    if (cmd.read0) value_r <= rd_val;
  end

  // expression state; emit returns it to the start of a new expression
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      acc        <= '0;
      neg        <= 1'b0;
      after_op   <= 1'b1;
      frac_flag  <= 1'b0;
      frac_val   <= '0;
      err        <= ST_OK;
      opnd_count <= '0;
      opr_count  <= '0;
      for (int k = 0; k < OPERAND_DEPTH; k++) opnd[k] <= '0;
      for (int k = 0; k < OPERATOR_DEPTH; k++) opr[k] <= '0;
    end else begin
      if (cmd.mac) begin
        acc      <= 16'(acc * radix + {11'd0, sym});
        after_op <= 1'b0;
      end
      if (cmd.set_neg) neg <= 1'b1;
      if (cmd.mark_bad && err == ST_OK) err <= ST_MALFORMED;
      if (cmd.push_num) begin
        acc <= '0;
        neg <= 1'b0;
      end
      if (push && opnd_count < CW'(OPERAND_DEPTH)) begin
        opnd[opnd_count[IW-1:0]] <= push_val;
        opnd_count <= opnd_count + CW'(1);
      end
      if ((cmd.pop_b || cmd.pop_a) && opnd_count != '0) begin
        opnd_count <= opnd_dec;
      end
      if (cmd.pop_op) opr_count <= opr_count - 2'd1;
      if (cmd.push_op) begin
        if (opr_count != 2'd2) begin
          opr[opr_count[0]] <= sym[1:0];
          opr_count <= opr_count + 2'd1;
        end
        after_op <= 1'b1;
      end
      if (cmd.exec && cur_op == OP_DIV && opb == 16'd0 && err == ST_OK) begin
        err <= ST_DIV_ZERO;
      end
      if (div_done && div_rem_nz) begin
        frac_flag <= 1'b1;
        frac_val  <= div_frac;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      value                <= (final_st == ST_OK) ? value_r : 16'd0;
      status               <= final_st;
      has_fraction         <= (final_st == ST_OK) && frac_flag;
      fraction_thousandths <= (final_st == ST_OK) ? frac_val : 10'd0;
    end
  end

  `IEE_ASSERT_NOW(a_opnd_bound, clk, rst, 1'b1, opnd_count <= CW'(OPERAND_DEPTH), "operand count overflow")
  `IEE_ASSERT_NOW(a_opr_pop, clk, rst, cmd.pop_op, opr_count != 2'd0, "pop from empty operator stack")
  `IEE_ASSERT_NOW(a_emit_slot, clk, rst, cmd.emit, !out_valid || out_ready, "result overwritten")
  `IEE_ASSERT_NEXT(a_emit_clear, clk, rst, cmd.emit, opnd_count == '0 && err == ST_OK && out_valid, "expression not cleared on result")

endmodule

### rtl/infix_expression_evaluator.sv
// Top level of the infix expression evaluator.
// Depends on iee_pkg, iee_ctrl and iee_dp (which holds iee_div).
//
// Usage:
//   Symbols arrive on the input channel (in_valid/in_ready): symbol is a
//   digit 0..15 or an operator code, last marks the end of an expression.
//   One result per expression leaves on the output channel
//   (out_valid/out_ready) with value, status, has_fraction and
//   fraction_thousandths.
//   The radix register is written through cfg_wr_en/cfg_wr_data; the user
//   must do so only while idle, as the block itself does not enforce it.
//   One symbol is worked at a time. A reduction pops the operator and both
//   operands, executes and pushes the result; a division runs in the
//   bit-serial divider (16 quotient and 10 fraction steps, the fraction
//   steps skipped when exact).
// Reset and stall:
//   rst (synchronous) sets radix to 10 and starts a new expression.
//   A waiting result is held in the output register; new symbols are still
//   taken, and only the next result waits until the slot is free.
module infix_expression_evaluator
  import iee_pkg::*;
#(
  parameter int OPERAND_DEPTH = OPERAND_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  symbol,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] value,
  output logic [1:0]  status,
  output logic        has_fraction,
  output logic [9:0]  fraction_thousandths
);

  iee_cmd_t    cmd;
  iee_stat_t   stat;
  logic [15:0] value_u;

  iee_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  iee_dp #(
    .OPERAND_DEPTH (OPERAND_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .symbol               (symbol),
    .last                 (last),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .value                (value_u),
    .status               (status),
    .has_fraction         (has_fraction),
    .fraction_thousandths (fraction_thousandths)
  );

  assign value = $signed(value_u);

endmodule

### bench/infix_expression_evaluator_tb.sv
`timescale 1ns / 1ps
// Testbench for infix_expression_evaluator: symbol requests from a queue,
// results checked against an in-bench expression predictor. Needs iee_pkg.
module infix_expression_evaluator_tb;
  import iee_pkg::*;

  typedef struct packed {
    logic [4:0] sym;
    logic       lst;
  } sym_req_t;

  typedef struct packed {
    logic [15:0] val;
    logic [1:0]  st;
    logic        frac;
    logic [9:0]  thou;
  } eval_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = 5'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  symbol = 5'd0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [15:0] value;
  logic [1:0]  status;
  logic        has_fraction;
  logic [9:0]  fraction_thousandths;

  infix_expression_evaluator u_top (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .symbol(symbol), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .value(value),
    .status(status), .has_fraction(has_fraction),
    .fraction_thousandths(fraction_thousandths)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sym_req_t  pending_syms[$];
  eval_res_t expected_results[$];
  int        errors = 0;
  int        n_sent = 0;
  int        n_results = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        hold_off = 0;

  // predictor state
  logic [4:0]  p_radix;
  logic [15:0] p_opnd[3];
  int          p_opnd_n;
  iee_op_t     p_oper[2];
  int          p_oper_n;
  logic [15:0] p_acc;
  logic        p_neg, p_after_op, p_frac;
  logic [9:0]  p_thou;
  logic [1:0]  p_err;

  function automatic void clear_expr();
    for (int k = 0; k < 3; k++) p_opnd[k] = '0;
    p_oper[0] = OP_PLUS;
    p_oper[1] = OP_PLUS;
    p_opnd_n = 0;
    p_oper_n = 0;
    p_acc = '0;
    p_neg = 1'b0;
    p_after_op = 1'b1;
    p_frac = 1'b0;
    p_thou = '0;
    p_err = ST_OK;
  endfunction

  function automatic void push_opnd(logic [15:0] v);
    if (p_opnd_n < 3) begin
      p_opnd[p_opnd_n] = v;
      p_opnd_n++;
    end
  endfunction

  function automatic logic [15:0] pop_opnd();
    if (p_opnd_n == 0) return '0;
    p_opnd_n--;
    return p_opnd[p_opnd_n];
  endfunction

  function automatic logic [15:0] quotient(logic [15:0] a, logic [15:0] b);
    int sa, sb, q, r, ra, rb;
    sa = $signed(a);
    sb = $signed(b);
    if (sb == 0) begin
      if (p_err == ST_OK) p_err = ST_DIV_ZERO;
      return '0;
    end
    q = sa / sb;
    r = sa % sb;
    if (r != 0) begin
      ra = r < 0 ? -r : r;
      rb = sb < 0 ? -sb : sb;
      p_frac = 1'b1;
      p_thou = 10'((ra * 1000) / rb);
    end
    return q[15:0];
  endfunction

  function automatic void reduce_top();
    iee_op_t op;
    logic [15:0] a, b, r;
    if (p_oper_n == 0) return;
    p_oper_n--;
    op = p_oper[p_oper_n];
    b = pop_opnd();
    a = pop_opnd();
    case (op)
      OP_PLUS:  r = a + b;
      OP_MINUS: r = a - b;
      OP_TIMES: r = a * b;
      default:  r = quotient(a, b);
    endcase
    push_opnd(r);
  endfunction

  function automatic void push_number();
    push_opnd(p_neg ? 16'(-p_acc) : p_acc);
    p_acc = '0;
    p_neg = 1'b0;
  endfunction

  function automatic void take_operator(iee_op_t op);
    if (op == OP_MINUS && p_after_op) begin
      p_neg = 1'b1;
      return;
    end
    push_number();
    if (op == OP_PLUS || op == OP_MINUS) begin
      while (p_oper_n > 0) reduce_top();
    end else begin
      while (p_oper_n > 0 && p_oper[p_oper_n-1] inside {OP_TIMES, OP_DIV}) reduce_top();
    end
    if (p_oper_n < 2) begin
      p_oper[p_oper_n] = op;
      p_oper_n++;
    end
    p_after_op = 1'b1;
  endfunction

  // Advance the predictor by one symbol; queue a result on the last one.
  function automatic void predict_symbol(sym_req_t q);
    logic dig, opr;
    logic [1:0] st;
    logic [15:0] v;
    eval_res_t res;
    dig = q.sym < SYM_PLUS;
    opr = q.sym >= SYM_PLUS && q.sym <= SYM_DIVIDE;
    v = '0;
    if (dig) begin
      p_acc = 16'(p_acc * p_radix + q.sym);
      p_after_op = 1'b0;
    end else if (opr) begin
      if (!q.lst) take_operator(iee_op_t'(q.sym - SYM_PLUS));
    end else if (p_err == ST_OK) begin
      p_err = ST_MALFORMED;
    end
    if (!q.lst) return;
    if (dig) begin
      push_number();
      while (p_oper_n > 0) reduce_top();
      v = p_opnd[0];
    end
    st = p_err;
    if (st == ST_OK && opr) st = ST_MALFORMED;
    if (st == ST_OK) res = '{val: v, st: ST_OK, frac: p_frac, thou: p_thou};
    else res = '{val: '0, st: st, frac: 1'b0, thou: '0};
    expected_results.push_back(res);
    clear_expr();
  endfunction

  // Driver: offer the next pending request, predicting it when accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_symbol('{sym: symbol, lst: last});
        n_sent++;
      end
      if (!(in_valid && !in_ready)) begin
        if (pending_syms.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          symbol <= pending_syms[0].sym;
          last <= pending_syms[0].lst;
          void'(pending_syms.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready, with a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    eval_res_t exp_r;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%0d status=%0d", $time, value, status);
      end else begin
        exp_r = expected_results.pop_front();
        if (value !== exp_r.val || status !== exp_r.st || has_fraction !== exp_r.frac
            || fraction_thousandths !== exp_r.thou) begin
          errors++;
          $display("%0t: mismatch expected val=%0d st=%0d frac=%0d thou=%0d,",
                   $time, $signed(exp_r.val), exp_r.st, exp_r.frac, exp_r.thou);
          $display("    actual val=%0d st=%0d frac=%0d thou=%0d",
                   value, status, has_fraction, fraction_thousandths);
        end
      end
    end
  end

  task automatic add_sym(logic [4:0] s, logic l);
    pending_syms.push_back('{sym: s, lst: l});
  endtask

  // Random number of one to three digits, mostly valid in the radix.
  task automatic add_number(int rdx, logic l);
    int nd;
    nd = $urandom_range(1, 3);
    for (int k = 0; k < nd; k++) begin
      add_sym(($urandom_range(9) == 0) ? 5'($urandom_range(15)) : 5'($urandom_range(rdx - 1)),
              l && (k == nd - 1));
    end
  endtask

  task automatic add_expression(int rdx);
    int nterm;
    logic [4:0] endsym;
    if ($urandom_range(9) == 0) begin
      // noise: raw random symbols, with unused codes too
      nterm = $urandom_range(1, 6);
      for (int k = 0; k < nterm; k++) add_sym(5'($urandom), k == nterm - 1);
      return;
    end
    nterm = $urandom_range(1, 4);
    for (int k = 0; k < nterm; k++) begin
      if ($urandom_range(3) == 0) add_sym(SYM_MINUS, 1'b0);
      if (k == nterm - 1) begin
        if ($urandom_range(11) == 0) begin
          endsym = 5'($urandom_range(16, 19));
          add_number(rdx, 1'b0);
          add_sym(endsym, 1'b1);
        end else begin
          add_number(rdx, 1'b1);
        end
      end else begin
        add_number(rdx, 1'b0);
        add_sym(5'($urandom_range(16, 19)), 1'b0);
      end
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while ((pending_syms.size() > 0 || in_valid || expected_results.size() > 0)
           && guard < 400000) begin
      @(posedge clk);
      guard++;
    end
    // let any symbol that has no result finish inside the block
    repeat (100) @(posedge clk);
  endtask

  task automatic set_radix(logic [4:0] r);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    p_radix = r;
  endtask

  task automatic run_phase(int rdx, int exprs, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int k = 0; k < exprs; k++) add_expression(rdx);
    drain();
  endtask

  initial begin
    p_radix = RADIX_RESET;
    clear_expr();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, every operator, special cases (radix 10 at reset)
    add_sym(5'd1, 1'b0); add_sym(SYM_PLUS, 1'b0); add_sym(5'd2, 1'b0);
    add_sym(5'd18, 1'b0); add_sym(5'd3, 1'b1);                  // 1+2*3
    add_sym(5'd7, 1'b0); add_sym(SYM_DIVIDE, 1'b0); add_sym(5'd2, 1'b1);
    add_sym(5'd7, 1'b0); add_sym(SYM_DIVIDE, 1'b0); add_sym(5'd0, 1'b1);
    add_sym(SYM_MINUS, 1'b0); add_sym(SYM_MINUS, 1'b0); add_sym(5'd5, 1'b0);
    add_sym(SYM_MINUS, 1'b0); add_sym(5'd9, 1'b1);              // --5-9
    add_sym(5'd4, 1'b0); add_sym(SYM_PLUS, 1'b1);               // ends in operator
    add_sym(5'd4, 1'b0); add_sym(5'd25, 1'b0); add_sym(5'd15, 1'b1);
    add_sym(5'd31, 1'b1);
    add_sym(5'd3, 1'b0); add_sym(5'd18, 1'b0); add_sym(SYM_PLUS, 1'b1);
    drain();
    set_radix(5'd16);
    // most negative quotient: -0x8000 / -1
    add_sym(SYM_MINUS, 1'b0); add_sym(5'd8, 1'b0);
    for (int k = 0; k < 3; k++) add_sym(5'd0, 1'b0);
    add_sym(SYM_DIVIDE, 1'b0); add_sym(SYM_MINUS, 1'b0); add_sym(5'd1, 1'b1);
    add_sym(5'd15, 1'b0); add_sym(5'd15, 1'b0); add_sym(5'd15, 1'b0);
    add_sym(5'd15, 1'b0); add_sym(5'd18, 1'b0); add_sym(5'd15, 1'b1);
    drain();

    // pressure: receiver held off while the sender keeps offering
    hold_off = 600;
    run_phase(16, 10, 0, 0);
    run_phase(16, 25, 0, 0);
    set_radix(5'd2);
    run_phase(2, 25, 86, 0);
    set_radix(5'd10);
    run_phase(10, 25, 0, 86);
    set_radix(5'd31);
    run_phase(10, 15, 21, 21);
    set_radix(5'd0);
    run_phase(10, 8, 0, 0);
    set_radix(5'd10);
    run_phase(10, 20, 21, 21);

    $display("Sent %0d symbols and checked %0d results over radix 2, 10, 16 and odd values,",
             n_sent, n_results);
    $display("with sender idling, receiver stalls and a long output hold-off.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### infix_expression_evaluator.f
+incdir+rtl
rtl/iee_pkg.sv
rtl/iee_div.sv
rtl/iee_ctrl.sv
rtl/iee_dp.sv
rtl/infix_expression_evaluator.sv
bench/infix_expression_evaluator_tb.sv
